[rtl/assert_macros.svh]
// Assertion helpers for the RTL, included by bracket_list_tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is asserted.
`define BLT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: the consequent is checked on the cycle after the antecedent.
`define BLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/blt_pkg.sv]
// ----------------------------------------------------------------------------
// blt_pkg
// Types, character codes and lexical helpers for the bracket list tokenizer.
// ----------------------------------------------------------------------------
package blt_pkg;

  localparam int MaxRes    = 4;
  // A dot pending after an integer can take three passes: number, identifier,
  // then the byte itself from idle.
  localparam int ScanSteps = 3;

  localparam logic [7:0] ChLbr   = 8'h5B;  // '['
  localparam logic [7:0] ChRbr   = 8'h5D;  // ']'
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChUnder = 8'h5F;  // '_'
  localparam logic [7:0] ChSlash = 8'h2F;  // '/'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_MINUS = 3'd1,
    MODE_INT   = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_FRAC  = 3'd4,
    MODE_IDENT = 3'd5,
    MODE_ERROR = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    KIND_LBR   = 3'd0,
    KIND_RBR   = 3'd1,
    KIND_COMMA = 3'd2,
    KIND_NUM   = 3'd3,
    KIND_IDENT = 3'd4,
    KIND_END   = 3'd5,
    KIND_BAD   = 3'd6,
    KIND_LONG  = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  bad_char;
    logic        last_of_run;
  } out_item_t;

  typedef out_item_t [MaxRes-1:0] res_vec_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == ChUnder) || (c == ChSlash) || (c == ChDot);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c == ChCr) || (c == ChTab) || (c == ChLf);
  endfunction

  function automatic out_item_t mk_res(kind_e k, logic [15:0] start,
                                       logic [15:0] len, logic [7:0] bad);
    out_item_t r;
    r.kind         = k;
    r.token_start  = start;
    r.token_length = len;
    r.bad_char     = bad;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Appends a token at slot n; tokens beyond the buffer depth are dropped.
  function automatic res_vec_t push(res_vec_t v, logic [2:0] n, out_item_t r);
    res_vec_t o;
    o = v;
    if (n < 3'(MaxRes)) begin
      o[n[1:0]] = r;
    end
    return o;
  endfunction

endpackage

[rtl/bracket_list_tokenizer.sv]
// ----------------------------------------------------------------------------
// bracket_list_tokenizer
// Streaming scanner: one source byte per transaction in, tokens out as
// kind, start offset and length.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (blt_pkg::in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (blt_pkg::out_item_t)
//
// A byte is registered, then scanned into a 4-entry token buffer once the buffer is
// empty or hands out its last token; the byte's first token is then offered from it.
// Sustained rate is one byte per cycle while bytes yield at most one token and
// out_stall_i is low; a byte that yields k tokens (k up to 4) stalls the input while
// the buffer drains one token per cycle that out_stall_i is low. Scan state, position
// and valid bits clear on reset; no clearing pass. Output stall backs up into in_stall_o within the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_list_tokenizer #(
  parameter int POS_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  blt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output blt_pkg::out_item_t out_data_o
);

  // input register
  logic              s1_valid_q, s1_valid_d;
  blt_pkg::in_item_t s1_data_q;

  // scan state
  blt_pkg::mode_e       mode_q, mode_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [POS_WIDTH-1:0] begin_q, begin_d;

  // token buffer
  blt_pkg::res_vec_t res_q;
  blt_pkg::res_vec_t res_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [1:0]        idx_q, idx_d;

  logic in_fire, out_fire, last_out, go;

  logic [2:0]        n;
  logic [2:0]        n_eff;
  logic              done;
  logic [7:0]        c;
  logic [POS_WIDTH-1:0] fp;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = res_q[idx_q];
  assign out_fire    = out_valid_o & ~out_stall_i;
  assign last_out    = (idx_q == 2'(cnt_q - 3'd1));
  assign go          = s1_valid_q & ((cnt_q == 3'd0) | (out_fire & last_out));
  assign in_stall_o  = s1_valid_q & ~go;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_fire | (s1_valid_q & ~go);

  // Scan one byte: run the lookahead states, then flush on end of source.
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    res_d   = '0;
    n       = 3'd0;
    done    = 1'b0;
    c       = s1_data_q.ch;
    fp      = '0;

    if (mode_q == blt_pkg::MODE_ERROR) begin
      if (s1_data_q.end_of_source) begin
        mode_d  = blt_pkg::MODE_IDLE;
        pos_d   = '0;
        begin_d = '0;
      end
    end else begin
      if (s1_data_q.has_char) begin
        if (pos_q == '1) begin
          res_d  = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_LONG,
                                 16'(pos_q), 16'd0, 8'd0));
          n      = n + 3'd1;
          mode_d = blt_pkg::MODE_ERROR;
        end else begin
          for (int k = 0; k < blt_pkg::ScanSteps; k++) begin
            if (!done) begin
              case (mode_d)
                blt_pkg::MODE_IDLE: begin
                  begin_d = pos_q;
                  done    = 1'b1;
                  if (c == blt_pkg::ChLbr) begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_LBR,
                                          16'(pos_q), 16'd1, 8'd0));
                    n = n + 3'd1;
                  end else if (c == blt_pkg::ChRbr) begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_RBR,
                                          16'(pos_q), 16'd1, 8'd0));
                    n = n + 3'd1;
                  end else if (c == blt_pkg::ChComma) begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_COMMA,
                                          16'(pos_q), 16'd1, 8'd0));
                    n = n + 3'd1;
                  end else if (blt_pkg::is_space(c)) begin
                    mode_d = blt_pkg::MODE_IDLE;
                  end else if (c == blt_pkg::ChMinus) begin
                    mode_d = blt_pkg::MODE_MINUS;
                  end else if (blt_pkg::is_digit(c)) begin
                    mode_d = blt_pkg::MODE_INT;
                  end else if (blt_pkg::is_ident_start(c)) begin
                    mode_d = blt_pkg::MODE_IDENT;
                  end else begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_BAD,
                                          16'(pos_q), 16'd1, c));
                    n      = n + 3'd1;
                    mode_d = blt_pkg::MODE_ERROR;
                  end
                end
                blt_pkg::MODE_MINUS: begin
                  done = 1'b1;
                  if (blt_pkg::is_digit(c)) begin
                    mode_d = blt_pkg::MODE_INT;
                  end else begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_BAD,
                                          16'(begin_d), 16'd1, blt_pkg::ChMinus));
                    n      = n + 3'd1;
                    mode_d = blt_pkg::MODE_ERROR;
                  end
                end
                blt_pkg::MODE_INT: begin
                  if (blt_pkg::is_digit(c)) begin
                    done = 1'b1;
                  end else if (c == blt_pkg::ChDot) begin
                    mode_d = blt_pkg::MODE_DOT;
                    done   = 1'b1;
                  end else begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_NUM,
                                          16'(begin_d), 16'(pos_q - begin_d), 8'd0));
                    n      = n + 3'd1;
                    mode_d = blt_pkg::MODE_IDLE;
                  end
                end
                blt_pkg::MODE_DOT: begin
                  if (blt_pkg::is_digit(c)) begin
                    mode_d = blt_pkg::MODE_FRAC;
                    done   = 1'b1;
                  end else begin
                    // number ends before the dot; the dot opens an identifier
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_NUM,
                                          16'(begin_d),
                                          16'(pos_q - POS_WIDTH'(1) - begin_d), 8'd0));
                    n       = n + 3'd1;
                    begin_d = pos_q - POS_WIDTH'(1);
                    mode_d  = blt_pkg::MODE_IDENT;
                  end
                end
                blt_pkg::MODE_FRAC: begin
                  if (blt_pkg::is_digit(c)) begin
                    done = 1'b1;
                  end else begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_NUM,
                                          16'(begin_d), 16'(pos_q - begin_d), 8'd0));
                    n      = n + 3'd1;
                    mode_d = blt_pkg::MODE_IDLE;
                  end
                end
                blt_pkg::MODE_IDENT: begin
                  if (blt_pkg::is_digit(c) || blt_pkg::is_ident_start(c)) begin
                    done = 1'b1;
                  end else begin
                    res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_IDENT,
                                          16'(begin_d), 16'(pos_q - begin_d), 8'd0));
                    n      = n + 3'd1;
                    mode_d = blt_pkg::MODE_IDLE;
                  end
                end
                default: begin
                  done = 1'b1;
                end
              endcase
            end
          end
          pos_d = pos_q + POS_WIDTH'(1);
        end
      end

      if (s1_data_q.end_of_source) begin
        fp = pos_d;
        case (mode_d)
          blt_pkg::MODE_MINUS: begin
            // lone minus: error, no end token
            res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_BAD,
                                  16'(begin_d), 16'd1, blt_pkg::ChMinus));
            n = n + 3'd1;
          end
          blt_pkg::MODE_INT, blt_pkg::MODE_FRAC: begin
            res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_NUM,
                                  16'(begin_d), 16'(fp - begin_d), 8'd0));
            n = n + 3'd1;
          end
          blt_pkg::MODE_DOT: begin
            res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_NUM,
                                  16'(begin_d), 16'(fp - POS_WIDTH'(1) - begin_d), 8'd0));
            n = n + 3'd1;
            res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_IDENT,
                                  16'(fp - POS_WIDTH'(1)), 16'd1, 8'd0));
            n = n + 3'd1;
          end
          blt_pkg::MODE_IDENT: begin
            res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_IDENT,
                                  16'(begin_d), 16'(fp - begin_d), 8'd0));
            n = n + 3'd1;
          end
          default: begin
          end
        endcase
        if ((mode_d != blt_pkg::MODE_MINUS) && (mode_d != blt_pkg::MODE_ERROR)) begin
          res_d = blt_pkg::push(res_d, n, blt_pkg::mk_res(blt_pkg::KIND_END,
                                16'(fp), 16'd0, 8'd0));
          n = n + 3'd1;
        end
        mode_d  = blt_pkg::MODE_IDLE;
        pos_d   = '0;
        begin_d = '0;
      end
    end

    n_eff = (n > 3'(blt_pkg::MaxRes)) ? 3'(blt_pkg::MaxRes) : n;
    for (int i = 0; i < blt_pkg::MaxRes; i++) begin
      res_d[i].last_of_run = (n_eff == 3'(i + 1));
    end
  end

  // buffer control
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (go) begin
      cnt_d = n_eff;
      idx_d = 2'd0;
    end else if (out_fire) begin
      if (last_out) begin
        cnt_d = 3'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mode_q     <= blt_pkg::MODE_IDLE;
      pos_q      <= '0;
      begin_q    <= '0;
      cnt_q      <= 3'd0;
      idx_q      <= 2'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      if (go) begin
        mode_q  <= mode_d;
        pos_q   <= pos_d;
        begin_q <= begin_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (go) begin
      res_q <= res_d;
    end
  end

  `BLT_ASSERT(a_idx_in_range, clk_i, rst_ni,
              (cnt_q != 3'd0) |-> (({1'b0, idx_q} < cnt_q) && (cnt_q <= 3'd4)),
              "token buffer index out of range")
  `BLT_ASSERT_NEXT(a_error_silent, clk_i, rst_ni,
                   go && (mode_q == blt_pkg::MODE_ERROR), cnt_q == 3'd0,
                   "tokens emitted after an error")
  `BLT_ASSERT_NEXT(a_eos_restart, clk_i, rst_ni,
                   go && s1_data_q.end_of_source,
                   (pos_q == '0) && (mode_q == blt_pkg::MODE_IDLE),
                   "scan did not restart after end of source")

endmodule

[dv/blt_token_checker.sv]
// ----------------------------------------------------------------------------
// blt_token_checker
// Watches both channels of the bracket list tokenizer, predicts the tokens
// each accepted source byte produces and compares every accepted token,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module blt_token_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  blt_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  blt_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  blt_pkg::mode_e     lex_mode    = blt_pkg::MODE_IDLE;
  logic [15:0]        next_offset = '0;
  logic [15:0]        tok_start   = '0;

  blt_pkg::out_item_t step_tokens[$];       // tokens caused by the current byte
  blt_pkg::out_item_t predicted_tokens[$];  // tokens not yet seen at the output
  blt_pkg::out_item_t oldest;
  int                 fail_total = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic bit is_numeral(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit starts_name(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == blt_pkg::ChUnder) || (c == blt_pkg::ChSlash) || (c == blt_pkg::ChDot);
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return (c == blt_pkg::ChSpace) || (c == blt_pkg::ChCr) || (c == blt_pkg::ChTab) ||
           (c == blt_pkg::ChLf);
  endfunction

  task automatic reset_scan();
    lex_mode    = blt_pkg::MODE_IDLE;
    next_offset = '0;
    tok_start   = '0;
  endtask

  task automatic emit(blt_pkg::kind_e k, logic [15:0] start, logic [15:0] len,
                      logic [7:0] bad);
    blt_pkg::out_item_t tok;
    tok = {k, start, len, bad, 1'b0};
    if (step_tokens.size() < blt_pkg::MaxRes) begin
      step_tokens = {step_tokens, tok};
    end
  endtask

  // A byte that closes a token is looked at again from idle, or from the name state after a pending dot.
  task automatic scan_byte(logic [7:0] c, logic [15:0] p);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lex_mode)
        blt_pkg::MODE_IDLE: begin
          tok_start = p;
          if (c == blt_pkg::ChLbr) emit(blt_pkg::KIND_LBR, p, 16'd1, 8'd0);
          else if (c == blt_pkg::ChRbr) emit(blt_pkg::KIND_RBR, p, 16'd1, 8'd0);
          else if (c == blt_pkg::ChComma) emit(blt_pkg::KIND_COMMA, p, 16'd1, 8'd0);
          else if (is_blank(c)) begin
          end
          else if (c == blt_pkg::ChMinus) lex_mode = blt_pkg::MODE_MINUS;
          else if (is_numeral(c)) lex_mode = blt_pkg::MODE_INT;
          else if (starts_name(c)) lex_mode = blt_pkg::MODE_IDENT;
          else begin
            emit(blt_pkg::KIND_BAD, p, 16'd1, c);
            lex_mode = blt_pkg::MODE_ERROR;
          end
        end
        blt_pkg::MODE_MINUS: begin
          if (is_numeral(c)) lex_mode = blt_pkg::MODE_INT;
          else begin
            emit(blt_pkg::KIND_BAD, tok_start, 16'd1, blt_pkg::ChMinus);
            lex_mode = blt_pkg::MODE_ERROR;
          end
        end
        blt_pkg::MODE_INT: begin
          if (c == blt_pkg::ChDot) lex_mode = blt_pkg::MODE_DOT;
          else if (!is_numeral(c)) begin
            emit(blt_pkg::KIND_NUM, tok_start, p - tok_start, 8'd0);
            lex_mode = blt_pkg::MODE_IDLE;
            again    = 1'b1;
          end
        end
        blt_pkg::MODE_DOT: begin
          if (is_numeral(c)) lex_mode = blt_pkg::MODE_FRAC;
          else begin
            // dot without a digit: number ends, the dot opens a name
            emit(blt_pkg::KIND_NUM, tok_start, p - 16'd1 - tok_start, 8'd0);
            tok_start = p - 16'd1;
            lex_mode  = blt_pkg::MODE_IDENT;
            again     = 1'b1;
          end
        end
        blt_pkg::MODE_FRAC: begin
          if (!is_numeral(c)) begin
            emit(blt_pkg::KIND_NUM, tok_start, p - tok_start, 8'd0);
            lex_mode = blt_pkg::MODE_IDLE;
            again    = 1'b1;
          end
        end
        blt_pkg::MODE_IDENT: begin
          if (!is_numeral(c) && !starts_name(c)) begin
            emit(blt_pkg::KIND_IDENT, tok_start, p - tok_start, 8'd0);
            lex_mode = blt_pkg::MODE_IDLE;
            again    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic flush_source();
    case (lex_mode)
      blt_pkg::MODE_MINUS: begin
        emit(blt_pkg::KIND_BAD, tok_start, 16'd1, blt_pkg::ChMinus);
        lex_mode = blt_pkg::MODE_ERROR;
        return;
      end
      blt_pkg::MODE_INT, blt_pkg::MODE_FRAC:
        emit(blt_pkg::KIND_NUM, tok_start, next_offset - tok_start, 8'd0);
      blt_pkg::MODE_DOT: begin
        emit(blt_pkg::KIND_NUM, tok_start, next_offset - 16'd1 - tok_start, 8'd0);
        emit(blt_pkg::KIND_IDENT, next_offset - 16'd1, 16'd1, 8'd0);
      end
      blt_pkg::MODE_IDENT: emit(blt_pkg::KIND_IDENT, tok_start, next_offset - tok_start, 8'd0);
      default: begin
      end
    endcase
    emit(blt_pkg::KIND_END, next_offset, 16'd0, 8'd0);
  endtask

  task automatic scan_item(blt_pkg::in_item_t it);
    step_tokens.delete();
    if (lex_mode == blt_pkg::MODE_ERROR) begin
      // rest of the source is dropped; its end only restarts the scanner
      if (it.end_of_source) reset_scan();
      return;
    end
    if (it.has_char) begin
      if (next_offset == 16'hFFFF) begin
        emit(blt_pkg::KIND_LONG, next_offset, 16'd0, 8'd0);
        lex_mode = blt_pkg::MODE_ERROR;
      end else begin
        scan_byte(it.ch, next_offset);
        next_offset = next_offset + 16'd1;
      end
    end
    if (it.end_of_source) begin
      if (lex_mode != blt_pkg::MODE_ERROR) flush_source();
      reset_scan();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    predicted_tokens = {predicted_tokens, step_tokens};
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: token %s mismatch: expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_scan();
      predicted_tokens.delete();
    end else begin
      if (in_valid_i && !in_stall_i) scan_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (predicted_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, actual kind %0d start %0d len %0d",
                   $time, out_data_i.kind, out_data_i.token_start, out_data_i.token_length);
          fail_total++;
        end else begin
          oldest = predicted_tokens.pop_front();
          check_field("kind", 16'(oldest.kind), 16'(out_data_i.kind));
          check_field("token_start", oldest.token_start, out_data_i.token_start);
          check_field("token_length", oldest.token_length, out_data_i.token_length);
          check_field("bad_char", 16'(oldest.bad_char), 16'(out_data_i.bad_char));
          check_field("last_of_run", 16'(oldest.last_of_run), 16'(out_data_i.last_of_run));
        end
      end
    end
    fail_count_o <= fail_total;
    pending_o    <= predicted_tokens.size();
  end

endmodule

[dv/tb_bracket_list_tokenizer.sv]
// ----------------------------------------------------------------------------
// tb_bracket_list_tokenizer
// Feeds the tokenizer directed sources and many random sources built from list
// lexemes and noise, under random gaps and output stalls.
// Prediction and comparison live in blt_token_checker.
// ----------------------------------------------------------------------------
module tb_bracket_list_tokenizer;

  localparam int         CycleLimit  = 1_000_000;
  localparam int         TailCycles  = 50;
  localparam int         RandomItems = 240;
  localparam logic [7:0] ChZero      = "0";
  localparam logic [7:0] ChLowA      = "a";
  localparam logic [7:0] ChUpA       = "A";

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  blt_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  blt_pkg::out_item_t out_data;

  int        fail_count;
  int        pending;

  bit         sender_gaps = 1'b1;
  logic [7:0] src_bytes[$];
  int         live_len;
  int         random_items = 0;
  int         source_count = 0;

  int stall_left   = 0;
  int phase_left   = 0;
  bit stall_enable = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bracket_list_tokenizer #(.POS_WIDTH(16)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  blt_token_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly short pauses, now and then a long one
  function automatic int rand_pause();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Receiver: stall bursts, in phases that sometimes have no stalls at all.
  always @(posedge clk) begin
    if (phase_left == 0) begin
      phase_left   <= $urandom_range(40, 400);
      stall_enable <= ($urandom_range(0, 3) != 0);
    end else begin
      phase_left <= phase_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (stall_enable && ($urandom_range(0, 99) < 30)) begin
      stall_left <= rand_pause() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb_bracket_list_tokenizer: done, errors");
    $finish;
  end

  function automatic blt_pkg::in_item_t make_item(logic [7:0] c, logic has, logic eos);
    return {c, has, eos};
  endfunction

  function automatic logic [7:0] rand_digit();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_name_start();
    case ($urandom_range(0, 3))
      0:       return ChLowA + 8'($urandom_range(0, 25));
      1:       return ChUpA + 8'($urandom_range(0, 25));
      2:       return ($urandom_range(0, 1) != 0) ? blt_pkg::ChUnder : blt_pkg::ChSlash;
      default: return blt_pkg::ChDot;
    endcase
  endfunction

  function automatic logic [7:0] rand_name_char();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_name_start();
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return blt_pkg::ChSpace;
      1:       return blt_pkg::ChTab;
      2:       return blt_pkg::ChCr;
      default: return blt_pkg::ChLf;
    endcase
  endfunction

  task automatic add_byte(logic [7:0] b);
    src_bytes = {src_bytes, b};
  endtask

  // Drive one transaction and return at the edge that accepts it.
  task automatic send_item(blt_pkg::in_item_t it);
    int gap;
    gap = (sender_gaps && ($urandom_range(0, 99) >= 55)) ? rand_pause() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Sends src_bytes as one source, ended on the last byte or by a bare marker.
  task automatic send_source(bit end_on_byte, bit bare_noise);
    foreach (src_bytes[i]) begin
      if (bare_noise && ($urandom_range(0, 24) == 0)) begin
        send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      send_item(make_item(src_bytes[i], 1'b1, end_on_byte && (i == src_bytes.size() - 1)));
    end
    if (!end_on_byte) send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  task automatic send_text(string s, bit end_on_byte);
    src_bytes.delete();
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_source(end_on_byte, 1'b0);
  endtask

  task automatic add_lexeme();
    case ($urandom_range(0, 7))
      0: add_byte(blt_pkg::ChLbr);
      1: add_byte(blt_pkg::ChRbr);
      2: add_byte(blt_pkg::ChComma);
      3, 4: begin
        if ($urandom_range(0, 2) == 0) add_byte(blt_pkg::ChMinus);
        repeat ($urandom_range(1, 4)) add_byte(rand_digit());
        case ($urandom_range(0, 4))
          0, 1: begin
            add_byte(blt_pkg::ChDot);
            repeat ($urandom_range(1, 3)) add_byte(rand_digit());
          end
          2: add_byte(blt_pkg::ChDot);  // dot left pending
          default: begin
          end
        endcase
      end
      5, 6: begin
        add_byte(rand_name_start());
        repeat ($urandom_range(0, 5)) add_byte(rand_name_char());
      end
      default: add_byte(rand_blank());
    endcase
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 2))
      0: add_byte(8'($urandom_range(0, 255)));
      1: begin
        // lone minus
        add_byte(blt_pkg::ChMinus);
        add_byte(($urandom_range(0, 1) != 0) ? rand_name_start() : rand_blank());
      end
      default: add_byte(8'($urandom_range(128, 255)));
    endcase
  endtask

  task automatic build_source();
    bit noisy;
    noisy = 1'b0;
    src_bytes.delete();
    repeat ($urandom_range(1, 10)) begin
      if (!noisy && ($urandom_range(0, 15) == 0)) begin
        add_noise();
        noisy    = 1'b1;
        live_len = src_bytes.size();
      end else begin
        add_lexeme();
      end
      case ($urandom_range(0, 5))
        0:       add_byte(blt_pkg::ChComma);
        1:       add_byte(rand_blank());
        default: begin
        end
      endcase
    end
    if (!noisy) live_len = src_bytes.size();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sources
    send_text("[-0.5,ab]", 1'b1);
    send_text("7.", 1'b0);
    send_text("1.]", 1'b1);
    send_item(make_item(8'hFF, 1'b0, 1'b1));  // empty source
    send_text("-x", 1'b1);
    send_text("-", 1'b0);
    send_text("\t\015\n.Z9", 1'b1);
    send_item(make_item(8'hFF, 1'b1, 1'b1));
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b0, 1'b0));  // bare item, no effect
    drain_outputs();

    while (random_items < RandomItems) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      build_source();
      send_source($urandom_range(0, 1) != 0, 1'b1);
      random_items += live_len + 1;
      source_count++;
      if (source_count == 12) drain_outputs();
    end

    drain_outputs();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_bracket_list_tokenizer: done, clean");
    end else begin
      $display("tb_bracket_list_tokenizer: done, errors");
    end
    $finish;
  end

endmodule

[bracket_list_tokenizer.f]
+incdir+rtl
rtl/blt_pkg.sv
rtl/bracket_list_tokenizer.sv
dv/blt_token_checker.sv
dv/tb_bracket_list_tokenizer.sv
